[hw/rtl/assert_macros.svh]
// Assertion helpers; the enclosing module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication
`define AST_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[hw/rtl/rbsi_pkg.sv]
package rbsi_pkg;

  // Coordinate width and fraction bits (Q16.16)
  localparam int W      = 32;
  localparam int Q_FRAC = 16;

  // Divider: magnitude of (plane - origin) scaled by 2^16, over |dir|
  localparam int DIV_NW = W + 1 + Q_FRAC;
  localparam int DIV_DW = W;

  localparam logic signed [W-1:0] S32_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] S32_MIN = {1'b1, {(W-1){1'b0}}};

  // Side data carried alongside the divider pipeline
  typedef struct packed {
    logic [2:0][W-1:0] org;
    logic [2:0][W-1:0] dir;
    logic [5:0]        neg;
    logic [2:0]        dz;
    logic              zmiss;
  } side_t;

endpackage

[hw/rtl/rbsi_div.sv]
module rbsi_div
  import rbsi_pkg::*;
#(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] n_r   [NW];
  logic [NW-1:0] q_r   [NW];
  logic [DW-1:0] d_r   [NW];

  // One quotient bit per stage, restoring form
  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] n_in;
    logic [NW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign n_in   = num;
      assign q_in   = '0;
      assign d_in   = den;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign n_in   = n_r[i-1];
      assign q_in   = q_r[i-1];
      assign d_in   = d_r[i-1];
    end

    assign trial = {rem_in, n_in[NW-1]};
    assign diff  = trial - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[DW]) begin
          rem_r[i] <= diff[DW-1:0];
          q_r[i]   <= {q_in[NW-2:0], 1'b1};
        end else begin
          rem_r[i] <= trial[DW-1:0];
          q_r[i]   <= {q_in[NW-2:0], 1'b0};
        end
        n_r[i] <= {n_in[NW-2:0], 1'b0};
        d_r[i] <= d_in;
      end
    end
  end

  assign quo = q_r[NW-1];

endmodule

[hw/rtl/ray_box_slab_intersection_top.sv]
// Channel | Group | tdata fields (lowest bits first)                     | tuser
// input   | in_*  | origin_x/y/z, dir_x/y/z, box_min_x/y/z, box_max_x/y/z  | -
// result  | out_* | hit_distance, point_x, point_y, point_z               | hit
//
// One request enters per cycle while no stalled result holds the pipeline; each result
// passes stage A, the bit-per-stage slab dividers and stages B to E.
// Reset (rst_n low, synchronous) empties the pipeline; no clearing pass.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module ray_box_slab_intersection_top
  import rbsi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit_distance, point_x, point_y, point_z
  output logic [127:0] out_tdata,
  // hit
  output logic [0:0]   out_tuser
);

  localparam int LAT = DIV_NW + 5;

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Saturate a divider magnitude with sign applied
  function automatic logic signed [W-1:0] qsat(input logic [DIV_NW-1:0] q, input logic neg);
    logic [W-1:0] m;
    logic [W-1:0] mn;
    m  = q[W-1:0];
    mn = -m;
    if (!neg) begin
      return (q >= DIV_NW'({1'b0, S32_MIN})) ? S32_MAX : $signed(m);
    end
    return (q > DIV_NW'({1'b0, S32_MIN})) ? S32_MIN : $signed(mn);
  endfunction

  // Stage A: plane offsets, magnitudes, zero-direction test
  logic [DIV_NW-1:0] a_num_r [6];
  logic [DIV_DW-1:0] a_den_r [3];
  side_t             side_r  [DIV_NW+1];
  side_t             side_a;
  logic [DIV_NW-1:0] num_a   [6];
  logic [DIV_DW-1:0] den_a   [3];

  always_comb begin
    logic signed [W-1:0] org, dir, lo, hi;
    logic signed [W:0]   d0, d1;
    logic [W:0]          m0, m1;
    side_a = '0;
    for (int a = 0; a < 3; a++) begin
      org = $signed(in_tdata[W*a +: W]);
      dir = $signed(in_tdata[W*(3+a) +: W]);
      lo  = $signed(in_tdata[W*(6+a) +: W]);
      hi  = $signed(in_tdata[W*(9+a) +: W]);
      d0  = {lo[W-1], lo} - {org[W-1], org};
      d1  = {hi[W-1], hi} - {org[W-1], org};
      m0  = d0[W] ? -d0 : d0;
      m1  = d1[W] ? -d1 : d1;
      num_a[2*a]   = {m0, {Q_FRAC{1'b0}}};
      num_a[2*a+1] = {m1, {Q_FRAC{1'b0}}};
      den_a[a]     = dir[W-1] ? -dir : dir;
      side_a.org[a]      = org;
      side_a.dir[a]      = dir;
      side_a.neg[2*a]    = d0[W] ^ dir[W-1];
      side_a.neg[2*a+1]  = d1[W] ^ dir[W-1];
      side_a.dz[a]       = (dir == '0);
      if ((dir == '0) && (((org < lo) && (org < hi)) || ((org > lo) && (org > hi)))) begin
        side_a.zmiss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) a_num_r[j] <= num_a[j];
      for (int a = 0; a < 3; a++) a_den_r[a] <= den_a[a];
      side_r[0] <= side_a;
    end
  end

  // Divider lanes, side data alongside
  logic [DIV_NW-1:0] quo [6];

  for (genvar j = 0; j < 6; j++) begin : g_div
    rbsi_div #(
      .NW(DIV_NW),
      .DW(DIV_DW)
    ) u_div (
      .clk(clk),
      .en (en),
      .num(a_num_r[j]),
      .den(a_den_r[j/2]),
      .quo(quo[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= DIV_NW; k++) side_r[k] <= side_r[k-1];
    end
  end

  // Stage B: signed slab distances, entry and exit per axis
  logic signed [W-1:0] b_en_r [3];
  logic signed [W-1:0] b_ex_r [3];
  side_t               b_side_r;

  always_ff @(posedge clk) begin
    logic signed [W-1:0] t0, t1;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        t0 = qsat(quo[2*a],   side_r[DIV_NW].neg[2*a]);
        t1 = qsat(quo[2*a+1], side_r[DIV_NW].neg[2*a+1]);
        if (side_r[DIV_NW].dz[a]) begin
          b_en_r[a] <= S32_MIN;
          b_ex_r[a] <= S32_MAX;
        end else begin
          b_en_r[a] <= (t0 < t1) ? t0 : t1;
          b_ex_r[a] <= (t0 < t1) ? t1 : t0;
        end
      end
      b_side_r <= side_r[DIV_NW];
    end
  end

  // Stage C: near, far and miss
  logic signed [W-1:0] c_near_r;
  logic                c_miss_r;
  side_t               c_side_r;

  always_ff @(posedge clk) begin
    logic signed [W-1:0] nr, fr;
    if (en) begin
      nr = b_en_r[0];
      fr = b_ex_r[0];
      for (int a = 1; a < 3; a++) begin
        if (b_en_r[a] > nr) nr = b_en_r[a];
        if (b_ex_r[a] < fr) fr = b_ex_r[a];
      end
      c_near_r <= nr;
      c_miss_r <= b_side_r.zmiss || (nr > fr) || fr[W-1];
      c_side_r <= b_side_r;
    end
  end

  // Stage D: near times direction
  logic signed [2*W-1:0] d_prod_r [3];
  logic signed [W-1:0]   d_near_r;
  logic                  d_miss_r;
  side_t                 d_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        d_prod_r[a] <= c_near_r * $signed(c_side_r.dir[a]);
      end
      d_near_r <= c_near_r;
      d_miss_r <= c_miss_r;
      d_side_r <= c_side_r;
    end
  end

  // Stage E: hit point, saturate, output register
  logic [127:0] out_data_r;
  logic         out_hit_r;

  always_ff @(posedge clk) begin
    logic signed [2*W-Q_FRAC-1:0] sh;
    logic signed [2*W-Q_FRAC:0]   sum;
    logic signed [W-1:0]          org;
    logic [W-1:0]                 pt;
    logic [127:0]                 dat;
    if (en) begin
      dat = '0;
      if (!d_miss_r) begin
        dat[W-1:0] = d_near_r;
        for (int a = 0; a < 3; a++) begin
          sh  = d_prod_r[a][2*W-1:Q_FRAC];
          org = $signed(d_side_r.org[a]);
          sum = {{(W-Q_FRAC+1){org[W-1]}}, org} + {sh[2*W-Q_FRAC-1], sh};
          if (sum > $signed({{(W-Q_FRAC+1){1'b0}}, S32_MAX})) begin
            pt = S32_MAX;
          end else if (sum < $signed({{(W-Q_FRAC+1){1'b1}}, S32_MIN})) begin
            pt = S32_MIN;
          end else begin
            pt = sum[W-1:0];
          end
          dat[W*(a+1) +: W] = pt;
        end
      end
      out_data_r <= dat;
      out_hit_r  <= !d_miss_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_hit_r;

  `include "assert_macros.svh"

  `AST_IMP(a_miss_zero, out_tvalid && !out_tuser[0], out_tdata == '0, "miss with nonzero data")
  `AST_NXT(a_enter, in_tvalid && in_tready, vld_r[0], "accepted request not in pipeline")
  `AST_NXT(a_freeze, !en, $stable(vld_r), "pipeline moved during stall")

endmodule

[tb/sv/tb_ray_box_slab_intersection_top.sv]
`timescale 1ns / 1ps

module tb_ray_box_slab_intersection_top;
  import rbsi_pkg::*;

  // One ray/box request; hit_info_t below holds its expected outcome
  typedef struct {
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
  } ray_box_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] hit_dst;
    logic signed [31:0] pt [3];
  } hit_info_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return S32_MAX;
    if (v < -128'sd2147483648) return S32_MIN;
    return v[31:0];
  endfunction

  // Slab intersection, computed exactly in wide arithmetic
  function automatic hit_info_t slab_hit(input ray_box_t r);
    hit_info_t h;
    logic signed [127:0] near_t, far_t, t0, t1, en, ex, p;
    logic signed [127:0] o, d, l, u, s0, s1;
    logic miss;
    near_t = -128'sd2147483648;
    far_t  = 128'sd2147483647;
    miss = 1'b0;
    for (int a = 0; a < 3; a++) begin
      o = r.org[a]; d = r.dir[a]; l = r.lo[a]; u = r.hi[a];
      if (d == 0) begin
        s0 = (l < u) ? l : u;
        s1 = (l < u) ? u : l;
        if (o < s0 || o > s1) miss = 1'b1;
      end else begin
        // SV signed division truncates toward zero, as required
        t0 = clamp32(((l - o) * 65536) / d);
        t1 = clamp32(((u - o) * 65536) / d);
        en = (t0 < t1) ? t0 : t1;
        ex = (t0 < t1) ? t1 : t0;
        if (en > near_t) near_t = en;
        if (ex < far_t) far_t = ex;
      end
    end
    if (near_t > far_t || far_t < 0) miss = 1'b1;
    h.hit = !miss;
    h.hit_dst = miss ? '0 : near_t[31:0];
    for (int a = 0; a < 3; a++) begin
      o = r.org[a]; d = r.dir[a];
      p = o + ((near_t * d) >>> 16);
      h.pt[a] = miss ? '0 : clamp32(p);
    end
    return h;
  endfunction

  // Scoreboard: queue of pending hit outcomes
  class hit_scoreboard;
    hit_info_t pending [$];
    int errors;

    function void note_request(ray_box_t r);
      pending.push_back(slab_hit(r));
    endfunction

    function void check_result(logic hit, logic [127:0] data);
      hit_info_t e;
      if (pending.size() == 0) begin
        $error("unexpected result hit=%0b data=%h", hit, data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) begin
        $error("hit exp %0b got %0b", e.hit, hit); errors++;
      end
      if (data[31:0] !== e.hit_dst) begin
        $error("hit_distance exp %0d got %0d", e.hit_dst, $signed(data[31:0])); errors++;
      end
      for (int a = 0; a < 3; a++)
        if (data[32*(a+1) +: 32] !== e.pt[a]) begin
          $error("point_%s exp %0d got %0d", a == 0 ? "x" : a == 1 ? "y" : "z",
                 e.pt[a], $signed(data[32*(a+1) +: 32]));
          errors++;
        end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [383:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [0:0]   out_tuser;

  hit_scoreboard sb = new();
  bit quiet_phase = 1'b0;
  bit stim_done = 1'b0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  ray_box_slab_intersection_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  function automatic logic [383:0] pack_request(ray_box_t r);
    logic [383:0] v;
    for (int a = 0; a < 3; a++) begin
      v[32*a +: 32]      = r.org[a];
      v[32*(3+a) +: 32]  = r.dir[a];
      v[32*(6+a) +: 32]  = r.lo[a];
      v[32*(9+a) +: 32]  = r.hi[a];
    end
    return v;
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(ray_box_t r);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_request(r);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r);
  endtask

  // Random coordinate: mostly moderate, sometimes extreme
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return ($urandom_range(0, 1)) ? S32_MAX : S32_MIN;
      2: return 0;
      default: return $signed($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_dir();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return $urandom();
      2: return ($urandom_range(0, 1)) ? S32_MAX : S32_MIN;
      3: return $signed($urandom_range(0, 8)) - 4;
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  // Build a ray aimed at (or near) a random box, or, one time in four, a fully random ray and box
  function automatic ray_box_t rand_ray();
    ray_box_t r;
    logic signed [31:0] c, e;
    bit aimed;
    aimed = $urandom_range(0, 3) != 0;
    for (int a = 0; a < 3; a++) begin
      if (aimed) begin
        c = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        e = $urandom_range(0, 32'h0008_0000);
        r.lo[a] = c - e; r.hi[a] = c + e;
        if ($urandom_range(0, 9) == 0) begin r.lo[a] = c + e; r.hi[a] = c - e; end
        r.org[a] = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        r.dir[a] = ($urandom_range(0, 9) == 0) ? 0 :
                   (c - r.org[a]) / $signed($urandom_range(1, 64))
                   + ($signed($urandom_range(0, 32'h4000)) - 32'sh2000);
      end else begin
        r.org[a] = rand_coord(); r.dir[a] = rand_dir();
        r.lo[a] = rand_coord();  r.hi[a] = rand_coord();
      end
    end
    return r;
  endfunction

  function automatic ray_box_t mk(logic signed [31:0] o, logic signed [31:0] d,
                                  logic signed [31:0] l, logic signed [31:0] h);
    ray_box_t r;
    for (int a = 0; a < 3; a++) begin
      r.org[a] = o; r.dir[a] = d; r.lo[a] = l; r.hi[a] = h;
    end
    return r;
  endfunction

  // Stimulus
  initial begin
    ray_box_t r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, zero directions, inside origin, swapped corners
    send_request(mk(0, 0, 0, 0));
    send_request(mk(32'sh0001_0000, 0, 0, 32'sh0002_0000));
    send_request(mk(32'sh0003_0000, 0, 0, 32'sh0002_0000));
    send_request(mk(S32_MIN, S32_MAX, S32_MIN, S32_MAX));
    send_request(mk(S32_MAX, S32_MIN, S32_MIN, S32_MAX));
    send_request(mk(S32_MIN, 1, S32_MAX, S32_MIN));
    send_request(mk(S32_MAX, -1, S32_MIN, S32_MAX));
    send_request(mk(32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    send_request(mk(32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    send_request(mk(32'sh0002_8000, 32'sh0001_0000, 32'sh0003_0000, 32'sh0002_0000));
    send_request(mk(-1, -1, -1, -1));
    send_request(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    send_request(mk(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    r = mk(32'sh0001_0000, 0, 0, 32'sh0002_0000);
    r.dir[1] = 32'sh0000_8000; r.org[1] = -32'sh0004_0000;
    send_request(r);
    r.org[2] = 32'sh0005_0000;
    send_request(r);
    r = mk(0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000);
    r.dir[0] = -32'sh0001_0000;
    send_request(r);
    for (int i = 0; i < 1400; i++) begin
      if (i == 1200) quiet_phase = 1'b1;
      send_request(rand_ray());
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side with random stalls
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 12);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser[0], out_tdata);
  end

  // Watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 2000) begin
      $display("FAIL ray_box_slab_intersection_top");
      $finish;
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS ray_box_slab_intersection_top");
    else
      $display("FAIL ray_box_slab_intersection_top");
    $finish;
  end

endmodule
